### hdl/pds_pkg.sv
package pds_pkg;

   // Field widths
   localparam int PX_W  = 25;
   localparam int M_W   = 9;
   localparam int N_W   = 4;
   localparam int C_W   = 12;
   localparam int ERR_W = 28;

   // Parameter defaults
   localparam int DIV_N_MAX_DEF = 8;
   localparam int FRAC_BITS_DEF = 16;

   localparam int REF_MHZ   = 50;
   localparam int ERR_BOUND = 9;
   localparam int ERR_FRAC  = 24;

   // Datapath widths, sized for FRAC_BITS up to 24 and N up to 8
   localparam int ACC_W = C_W + PX_W;          // c * px
   localparam int CP_W  = ACC_W + 3;           // c * px * n, m * unit
   localparam int BD_W  = 36;                  // best error, below 9 * unit * 8
   localparam int ALU_W = CP_W + N_W;          // cross products
   localparam int DEN_W = 33;                  // unit * best n
   localparam int Q_W   = ERR_W;               // quotient bits
   localparam int CNT_W = $clog2(Q_W);

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LO_CMP,
      ST_LO_ADD,
      ST_HI_CMP,
      ST_M_START,
      ST_M_CHECK,
      ST_D_SUB,
      ST_D_NEG,
      ST_CMP,
      ST_M_ADV,
      ST_C_ADV,
      ST_N_ADV,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [M_W-1:0]   mult_m;
      logic [N_W-1:0]   div_n;
      logic [C_W-1:0]   post_c;
      logic [ERR_W-1:0] ratio_error;
      logic             found;
   } result_type;

   // Smallest M tried for each N
   function automatic logic [M_W-1:0] min_m(input logic [N_W-1:0] n);
      logic [M_W-1:0] r;
      unique case (n)
         4'd1: r = M_W'(7);
         4'd2: r = M_W'(13);
         4'd3: r = M_W'(19);
         4'd4: r = M_W'(25);
         4'd5: r = M_W'(32);
         4'd6: r = M_W'(38);
         4'd7: r = M_W'(44);
         4'd8: r = M_W'(50);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Odd M restrictions for the larger N
   function automatic logic m_allowed(input logic [M_W-1:0] m, input logic [N_W-1:0] n);
      logic ok;
      if (!m[0]) begin
         ok = 1'b1;
      end else begin
         unique case (n)
            4'd1, 4'd2, 4'd3, 4'd4: ok = 1'b1;
            4'd5: ok = (m == M_W'(45)) || (m == M_W'(55)) || (m >= M_W'(61));
            4'd6: ok = (m == M_W'(45)) || (m == M_W'(57)) || (m == M_W'(63))
                       || (m >= M_W'(73));
            4'd7: ok = (m == M_W'(63)) || (m == M_W'(77)) || (m >= M_W'(85));
            4'd8: ok = (m >= M_W'(97));
            default: ok = 1'b0;
         endcase
      end
      return ok;
   endfunction

   // floor(50/n) << frac: c_lo = ceil(lo_num / px)
   function automatic logic [ACC_W-1:0] lo_num(input logic [N_W-1:0] n, input int frac);
      logic [5:0] q;
      unique case (n)
         4'd1: q = 6'd50;
         4'd2: q = 6'd25;
         4'd3: q = 6'd16;
         4'd4: q = 6'd12;
         4'd5: q = 6'd10;
         4'd6: q = 6'd8;
         4'd7: q = 6'd7;
         4'd8: q = 6'd6;
         default: q = '0;
      endcase
      return ACC_W'(q) << frac;
   endfunction

   // (32*n*n) << frac: c_hi = ceil(hi_num / px)
   function automatic logic [ACC_W-1:0] hi_num(input logic [N_W-1:0] n, input int frac);
      logic [ACC_W-1:0] nn;
      nn = ACC_W'(n) * ACC_W'(n);
      return (nn << 5) << frac;
   endfunction

   // k * (50 << frac)
   function automatic logic [CP_W-1:0] unit_mult(input logic [M_W-1:0] k, input int frac);
      logic [CP_W-1:0] p;
      p = CP_W'(k) * CP_W'(REF_MHZ);
      return p << frac;
   endfunction

endpackage

### hdl/pds_if.sv
interface pds_req_if;
   logic                       valid;
   logic                       ready;
   logic [pds_pkg::PX_W-1:0]   pixel_clock;

   modport source (output valid, output pixel_clock, input ready);
   modport sink   (input valid, input pixel_clock, output ready);
endinterface

interface pds_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pds_pkg::M_W-1:0]    mult_m;
   logic [pds_pkg::N_W-1:0]    div_n;
   logic [pds_pkg::C_W-1:0]    post_c;
   logic [pds_pkg::ERR_W-1:0]  ratio_error;
   logic                       found;

   modport source (output valid, output mult_m, output div_n, output post_c,
                   output ratio_error, output found, input ready);
   modport sink   (input valid, input mult_m, input div_n, input post_c,
                   input ratio_error, input found, output ready);
endinterface

### hdl/pds_addsub.sv
// Shared adder/subtractor; borrow flags a < b on subtract.
module pds_addsub (
   input  pds_pkg::alu_op_type        op,
   input  logic [pds_pkg::ALU_W-1:0]  a,
   input  logic [pds_pkg::ALU_W-1:0]  b,
   output logic [pds_pkg::ALU_W-1:0]  sum,
   output logic                       borrow
);

   logic [pds_pkg::ALU_W:0] full;

   always_comb begin
      unique case (op)
         pds_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
         pds_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default:          full = '0;
      endcase
   end

   assign sum    = full[pds_pkg::ALU_W-1:0];
   assign borrow = (op == pds_pkg::ALU_SUB) && full[pds_pkg::ALU_W];

endmodule

### hdl/pds_engine.sv
// Search sequencer: walks n, c, m and runs the final error division,
// with the wide adds, subtracts and compares through one shared add/sub unit.
module pds_engine #(
   parameter int DIV_N_MAX = pds_pkg::DIV_N_MAX_DEF,
   parameter int FRAC_BITS = pds_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pds_pkg::PX_W-1:0]   pixel_clock,
   output logic                       idle,
   input  logic                       res_ready,
   output logic                       res_valid,
   output pds_pkg::result_type        result
);

   localparam int ACC_W = pds_pkg::ACC_W;
   localparam int CP_W  = pds_pkg::CP_W;
   localparam int BD_W  = pds_pkg::BD_W;
   localparam int ALU_W = pds_pkg::ALU_W;
   localparam int DEN_W = pds_pkg::DEN_W;
   localparam int Q_W   = pds_pkg::Q_W;
   localparam int CNT_W = pds_pkg::CNT_W;
   localparam int M_W   = pds_pkg::M_W;
   localparam int N_W   = pds_pkg::N_W;
   localparam int C_W   = pds_pkg::C_W;
   localparam int PX_W  = pds_pkg::PX_W;

   pds_pkg::state_type state_ff, state_in;

   logic [PX_W-1:0]  px_ff,   px_in;
   logic [N_W-1:0]   n_ff,    n_in;
   logic [C_W-1:0]   c_ff,    c_in;
   logic [ACC_W-1:0] acc_ff,  acc_in;    // c * px
   logic [ACC_W-1:0] accp_ff, accp_in;   // (c - 1) * px
   logic [CP_W-1:0]  cpn_ff,  cpn_in;    // c * px * n
   logic [M_W-1:0]   m_ff,    m_in;
   logic [CP_W-1:0]  t_ff,    t_in;      // m * unit
   logic [CP_W-1:0]  d_ff,    d_in;
   logic [BD_W-1:0]  bd_ff,   bd_in;
   logic [N_W-1:0]   bn_ff,   bn_in;
   logic [M_W-1:0]   bm_ff,   bm_in;
   logic [C_W-1:0]   bc_ff,   bc_in;
   logic             found_ff, found_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [Q_W-1:0]   sh_ff,   sh_in;
   logic [Q_W-1:0]   q_ff,    q_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;

   pds_pkg::alu_op_type alu_op;
   logic [ALU_W-1:0]    alu_a, alu_b, alu_sum;
   logic                alu_borrow;
   logic [DEN_W:0]      rem_shift;

   pds_addsub u_addsub (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .sum    (alu_sum),
      .borrow (alu_borrow)
   );

   assign rem_shift = {rem_ff, sh_ff[Q_W-1]};

   // Operand select for the shared unit
   always_comb begin
      alu_op = pds_pkg::ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      unique case (state_ff)
         pds_pkg::ST_LO_CMP: begin
            alu_op = pds_pkg::ALU_SUB;
            alu_a  = ALU_W'(acc_ff);
            alu_b  = ALU_W'(pds_pkg::lo_num(n_ff, FRAC_BITS));
         end
         pds_pkg::ST_LO_ADD, pds_pkg::ST_C_ADV: begin
            alu_a = ALU_W'(acc_ff);
            alu_b = ALU_W'(px_ff);
         end
         pds_pkg::ST_HI_CMP: begin
            alu_op = pds_pkg::ALU_SUB;
            alu_a  = ALU_W'(accp_ff);
            alu_b  = ALU_W'(pds_pkg::hi_num(n_ff, FRAC_BITS));
         end
         pds_pkg::ST_D_SUB: begin
            alu_op = pds_pkg::ALU_SUB;
            alu_a  = ALU_W'(cpn_ff);
            alu_b  = ALU_W'(t_ff);
         end
         pds_pkg::ST_D_NEG: begin
            alu_op = pds_pkg::ALU_SUB;
            alu_a  = ALU_W'(t_ff);
            alu_b  = ALU_W'(cpn_ff);
         end
         pds_pkg::ST_CMP: begin
            // d / n < best_d / best_n, cross-multiplied
            alu_op = pds_pkg::ALU_SUB;
            alu_a  = ALU_W'(d_ff) * ALU_W'(bn_ff);
            alu_b  = ALU_W'(bd_ff) * ALU_W'(n_ff);
         end
         pds_pkg::ST_M_ADV: begin
            alu_a = ALU_W'(t_ff);
            alu_b = ALU_W'(pds_pkg::unit_mult(M_W'(1), FRAC_BITS));
         end
         pds_pkg::ST_DIV_STEP: begin
            alu_op = pds_pkg::ALU_SUB;
            alu_a  = ALU_W'(rem_shift);
            alu_b  = ALU_W'(den_ff);
         end
         default: begin
            alu_op = pds_pkg::ALU_ADD;
         end
      endcase
   end

   // Next state and datapath updates
   always_comb begin
      state_in = state_ff;
      px_in    = px_ff;
      n_in     = n_ff;
      c_in     = c_ff;
      acc_in   = acc_ff;
      accp_in  = accp_ff;
      cpn_in   = cpn_ff;
      m_in     = m_ff;
      t_in     = t_ff;
      d_in     = d_ff;
      bd_in    = bd_ff;
      bn_in    = bn_ff;
      bm_in    = bm_ff;
      bc_in    = bc_ff;
      found_in = found_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      idle      = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         pds_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               px_in    = pixel_clock;
               n_in     = N_W'(1);
               c_in     = '0;
               acc_in   = '0;
               accp_in  = '0;
               bd_in    = BD_W'(pds_pkg::ERR_BOUND * pds_pkg::REF_MHZ) << FRAC_BITS;
               bn_in    = N_W'(1);
               bm_in    = '0;
               bc_in    = '0;
               found_in = 1'b0;
               q_in     = '0;
               if ((pixel_clock >> FRAC_BITS) == '0) begin
                  state_in = pds_pkg::ST_DONE;    // below 1 MHz: no search
               end else begin
                  state_in = pds_pkg::ST_LO_CMP;
               end
            end
         end
         pds_pkg::ST_LO_CMP: begin
            state_in = alu_borrow ? pds_pkg::ST_LO_ADD : pds_pkg::ST_HI_CMP;
         end
         pds_pkg::ST_LO_ADD, pds_pkg::ST_C_ADV: begin
            accp_in  = acc_ff;
            acc_in   = alu_sum[ACC_W-1:0];
            c_in     = c_ff + C_W'(1);
            state_in = (state_ff == pds_pkg::ST_LO_ADD) ? pds_pkg::ST_LO_CMP
                                                        : pds_pkg::ST_HI_CMP;
         end
         pds_pkg::ST_HI_CMP: begin
            state_in = alu_borrow ? pds_pkg::ST_M_START : pds_pkg::ST_N_ADV;
         end
         pds_pkg::ST_M_START: begin
            cpn_in   = CP_W'(acc_ff) * CP_W'(n_ff);
            m_in     = pds_pkg::min_m(n_ff);
            t_in     = pds_pkg::unit_mult(pds_pkg::min_m(n_ff), FRAC_BITS);
            state_in = pds_pkg::ST_M_CHECK;
         end
         pds_pkg::ST_M_CHECK: begin
            priority if (m_ff > (M_W'(n_ff) << 5)) begin
               state_in = pds_pkg::ST_C_ADV;
            end else if (pds_pkg::m_allowed(m_ff, n_ff)) begin
               state_in = pds_pkg::ST_D_SUB;
            end else begin
               state_in = pds_pkg::ST_M_ADV;
            end
         end
         pds_pkg::ST_D_SUB: begin
            d_in     = alu_sum[CP_W-1:0];
            state_in = alu_borrow ? pds_pkg::ST_D_NEG : pds_pkg::ST_CMP;
         end
         pds_pkg::ST_D_NEG: begin
            d_in     = alu_sum[CP_W-1:0];
            state_in = pds_pkg::ST_CMP;
         end
         pds_pkg::ST_CMP: begin
            if (alu_borrow) begin
               bd_in    = d_ff[BD_W-1:0];
               bn_in    = n_ff;
               bm_in    = m_ff;
               bc_in    = c_ff;
               found_in = 1'b1;
            end
            state_in = pds_pkg::ST_M_ADV;
         end
         pds_pkg::ST_M_ADV: begin
            t_in     = alu_sum[CP_W-1:0];
            m_in     = m_ff + M_W'(1);
            state_in = pds_pkg::ST_M_CHECK;
         end
         pds_pkg::ST_N_ADV: begin
            if (n_ff == N_W'(DIV_N_MAX)) begin
               state_in = pds_pkg::ST_DIV_LOAD;
            end else begin
               n_in     = n_ff + N_W'(1);
               c_in     = '0;
               acc_in   = '0;
               accp_in  = '0;
               state_in = pds_pkg::ST_LO_CMP;
            end
         end
         pds_pkg::ST_DIV_LOAD: begin
            // error = floor(best_d * 2^24 / (unit * best_n)); top part is below den
            den_in   = DEN_W'(pds_pkg::unit_mult(M_W'(bn_ff), FRAC_BITS));
            rem_in   = DEN_W'(bd_ff >> 4);
            sh_in    = {bd_ff[3:0], {(Q_W-4){1'b0}}};
            cnt_in   = '0;
            state_in = found_ff ? pds_pkg::ST_DIV_STEP : pds_pkg::ST_DONE;
         end
         pds_pkg::ST_DIV_STEP: begin
            rem_in = alu_borrow ? rem_shift[DEN_W-1:0] : alu_sum[DEN_W-1:0];
            q_in   = {q_ff[Q_W-2:0], !alu_borrow};
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(Q_W - 1)) begin
               state_in = pds_pkg::ST_DONE;
            end
         end
         pds_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = pds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pds_pkg::ST_IDLE;
         end
      endcase
   end

   assign result.mult_m      = bm_ff;
   assign result.div_n       = found_ff ? bn_ff : '0;
   assign result.post_c      = bc_ff;
   assign result.ratio_error = q_ff;
   assign result.found       = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      n_ff     <= n_in;
      c_ff     <= c_in;
      acc_ff   <= acc_in;
      accp_ff  <= accp_in;
      cpn_ff   <= cpn_in;
      m_ff     <= m_in;
      t_ff     <= t_in;
      d_ff     <= d_in;
      bd_ff    <= bd_in;
      bn_ff    <= bn_in;
      bm_ff    <= bm_in;
      bc_ff    <= bc_in;
      found_ff <= found_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      sh_ff    <= sh_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
   end

endmodule

### hdl/pll_divider_search_top.sv
// PLL divider search. Each item on req_chan is a target pixel clock in MHz
// (unsigned fixed point with FRAC_BITS fraction bits, 25 bits total). The
// block searches N = 1..DIV_N_MAX, output divider C over
// ceil(floor(50/N)/px) .. ceil(32*N*N/px) and feedback M from a per-N minimum
// up to 32*N (with some odd M excluded for N >= 5), and returns on rsp_chan
// the M, N, C whose M/N lies nearest C*px/50, plus the absolute error as
// Q4.24 and a found flag. Errors are compared exactly; ties keep the first
// candidate in search order; with nothing below 9 (or a target under 1 MHz)
// all fields are zero and found is clear. One item is in work at a time:
// req_chan.ready is high only while the sequencer is idle. The wide adds,
// subtracts and compares run through one shared add/sub unit, one operation
// per cycle. For each (N, C, M) candidate the sequencer forms the difference,
// negates it if negative, compares it with the best so far and steps M;
// the final error division yields one quotient bit per step. A finished
// result sits in an output register, so a new item can be taken while it
// waits.
module pll_divider_search_top #(
   parameter int DIV_N_MAX = pds_pkg::DIV_N_MAX_DEF,   // 1..8
   parameter int FRAC_BITS = pds_pkg::FRAC_BITS_DEF    // 8..24
) (
   input  logic          clock,
   input  logic          reset,
   pds_req_if.sink       req_chan,
   pds_rsp_if.source     rsp_chan
);

   logic                 eng_idle;
   logic                 eng_start;
   logic                 eng_res_valid;
   logic                 eng_res_ready;
   pds_pkg::result_type  eng_result;

   logic                 rsp_valid_ff, rsp_valid_in;
   pds_pkg::result_type  rsp_data_ff,  rsp_data_in;

   // Input side: take an item whenever the sequencer is idle.
   assign req_chan.ready = eng_idle;
   assign eng_start      = req_chan.valid & eng_idle;

   pds_engine #(
      .DIV_N_MAX (DIV_N_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (eng_start),
      .pixel_clock (req_chan.pixel_clock),
      .idle        (eng_idle),
      .res_ready   (eng_res_ready),
      .res_valid   (eng_res_valid),
      .result      (eng_result)
   );

   // Output register: free when empty or being drained this cycle.
   assign eng_res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_res_ready) begin
         rsp_valid_in = eng_res_valid;
         if (eng_res_valid) begin
            rsp_data_in = eng_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.mult_m      = rsp_data_ff.mult_m;
   assign rsp_chan.div_n       = rsp_data_ff.div_n;
   assign rsp_chan.post_c      = rsp_data_ff.post_c;
   assign rsp_chan.ratio_error = rsp_data_ff.ratio_error;
   assign rsp_chan.found       = rsp_data_ff.found;

endmodule

### hdl/pds_checker.sv
module pds_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [pds_pkg::M_W-1:0]    rsp_mult_m,
   input logic [pds_pkg::N_W-1:0]    rsp_div_n,
   input logic [pds_pkg::C_W-1:0]    rsp_post_c,
   input logic [pds_pkg::ERR_W-1:0]  rsp_ratio_error,
   input logic                       rsp_found
);

   localparam logic [pds_pkg::ERR_W-1:0] ErrLimit =
      pds_pkg::ERR_W'(pds_pkg::ERR_BOUND) << pds_pkg::ERR_FRAC;

   // A waiting result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mult_m)
         && $stable(rsp_div_n) && $stable(rsp_post_c)
         && $stable(rsp_ratio_error) && $stable(rsp_found))
      else $error("result changed while stalled");

   // One item at a time: busy right after an accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting an item");

   // No solution reads as all zeros.
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_mult_m == '0 && rsp_div_n == '0
         && rsp_post_c == '0 && rsp_ratio_error == '0)
      else $error("nonzero fields without a solution");

   // A solution has a legal N and an error below the bound.
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_div_n != '0
         && rsp_div_n <= pds_pkg::N_W'(pds_pkg::DIV_N_MAX_DEF)
         && rsp_ratio_error < ErrLimit)
      else $error("solution out of range");

endmodule

bind pll_divider_search_top pds_checker u_pds_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_mult_m      (rsp_chan.mult_m),
   .rsp_div_n       (rsp_chan.div_n),
   .rsp_post_c      (rsp_chan.post_c),
   .rsp_ratio_error (rsp_chan.ratio_error),
   .rsp_found       (rsp_chan.found)
);
